// File: src/tpls_pkg.sv
// shared types, codes and constants of the top-two pitch lag search
package tpls_pkg;

  localparam int MAX_LAGS_DEF = 512;
  localparam int NORM_BIAS    = 14;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  localparam int LOG_STEPS    = 5;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_ENERGY = 2'd1;
  localparam logic [1:0] OP_LAG    = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [0:0] REG_ENERGY_SHIFT = 1'b0;

  // multiplier operand selects
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_XX   = 3'd1;
  localparam logic [2:0] MUL_ND1  = 3'd2;
  localparam logic [2:0] MUL_N1E  = 3'd3;
  localparam logic [2:0] MUL_ND0  = 3'd4;
  localparam logic [2:0] MUL_N0E  = 3'd5;
  localparam logic [2:0] MUL_ENT  = 3'd6;
  localparam logic [2:0] MUL_LEV  = 3'd7;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] corr_value;
    logic signed [15:0] sample_enter;
    logic signed [15:0] sample_leave;
    logic               last_lag;
  } in_item_t;

  typedef struct packed {
    logic [8:0] best_lag;
    logic [8:0] second_lag;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       log_step;
    logic [2:0] log_idx;
    logic       start_commit;
    logic [2:0] mul_sel;
    logic       num_cap;
    logic       hold_cap;
    logic       top_upd;
    logic       eacc;
    logic       sq_cap;
    logic       slide;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic gt;
    logic last_lag;
  } stat_t;

endpackage

// File: src/top_two_pitch_lag_search.sv
// top level of the top-two pitch lag search with its configuration register
//
//   channel  direction  transfer when            payload
//   in_      input      in_valid && !in_stall    in_item_t
//   out_     output     out_valid && !out_stall  out_item_t
//   apb      config     psel penable pwrite      energy_shift at byte address 0
//
// start item: 5-step log2 search, then commit; energy item: square, then accumulate
// lag item: a positive correlation is compared to the second, then the best, before the slide;
// one shared 16x32 multiplier is used for every square and cross product
// a final lag item then loads the result register, waiting while the last result is stalled
// reset is synchronous; the result register lets the next item in while out_stall holds
module top_two_pitch_lag_search
  import tpls_pkg::*;
#(
  parameter int MAX_LAGS = MAX_LAGS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  in_item_t          in_data,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [3:0] energy_shift_r;
  logic       cfg_wr;
  cmd_t       cmd;
  stat_t      stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_shift_r <= '0;
    end else if (cfg_wr && paddr[2] == REG_ENERGY_SHIFT) begin
      energy_shift_r <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_ENERGY_SHIFT) ? CFG_DW'(energy_shift_r) : '0;

  tpls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpls_datapath #(
    .MAX_LAGS (MAX_LAGS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .energy_shift (energy_shift_r),
    .cmd          (cmd),
    .stat         (stat),
    .out_data     (out_data)
  );

endmodule

// File: src/tpls_datapath.sv
// datapath: item register, log2 unit, shared multiplier, energy and top-two store
module tpls_datapath
  import tpls_pkg::*;
#(
  parameter int MAX_LAGS = MAX_LAGS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic [3:0] energy_shift,
  input  cmd_t      cmd,
  output stat_t     stat,
  output out_item_t out_data
);

  localparam int LAG_W = $clog2(MAX_LAGS);

  in_item_t           item_r;
  logic [31:0]        p_r;
  logic [4:0]         lg_r;
  logic signed [5:0]  norm_r;
  logic [31:0]        energy_r;
  logic signed [15:0] num0_r, num1_r;
  logic signed [31:0] den0_r, den1_r;
  logic [LAG_W-1:0]   lag0_r, lag1_r, lagc_r;
  logic signed [47:0] prod_r;
  logic signed [47:0] hold_r;
  logic signed [15:0] num_r;
  logic [31:0]        sqe_r;
  out_item_t          out_r;

  logic [4:0]         log_sh;
  logic [31:0]        p_sh;
  logic [5:0]         neg_ns;
  logic [31:0]        corr_u, shl, shr;
  logic signed [15:0] x;
  logic signed [15:0] num_cur;
  logic signed [15:0] opa;
  logic signed [31:0] opb;
  logic [31:0]        sq;
  logic [31:0]        energy_nxt;
  logic [LAG_W-1:0]   lagc_nxt;
  logic               gt;

  // binary search for the top set bit, one halving per step
  assign log_sh = 5'd16 >> cmd.log_idx;
  assign p_sh   = p_r >> log_sh;

  // normalizing shift of the correlation
  assign corr_u = item_r.corr_value;
  assign neg_ns = -norm_r;
  assign shl    = corr_u << neg_ns[4:0];
  assign shr    = corr_u >> norm_r[4:0];
  assign x      = norm_r[5] ? shl[15:0] : shr[15:0];

  assign num_cur = cmd.num_cap ? prod_r[30:15] : num_r;

  always_comb begin
    opa = x;
    opb = 32'(x);
    case (cmd.mul_sel)
      MUL_XX: begin
        opa = x;
        opb = 32'(x);
      end
      MUL_ND1: begin
        opa = num_cur;
        opb = den1_r;
      end
      MUL_N1E: begin
        opa = num1_r;
        opb = energy_r;
      end
      MUL_ND0: begin
        opa = num_r;
        opb = den0_r;
      end
      MUL_N0E: begin
        opa = num0_r;
        opb = energy_r;
      end
      MUL_ENT: begin
        opa = item_r.sample_enter;
        opb = 32'(item_r.sample_enter);
      end
      MUL_LEV: begin
        opa = item_r.sample_leave;
        opb = 32'(item_r.sample_leave);
      end
      default: begin
        opa = x;
        opb = 32'(x);
      end
    endcase
  end

  assign gt = $signed(hold_r[47:15]) > $signed(prod_r[47:15]);
  assign sq = prod_r[31:0] >> energy_shift;

  always_comb begin
    energy_nxt = energy_r + sqe_r - sq;
    if (energy_nxt[31] || energy_nxt == 32'd0) begin
      energy_nxt = 32'd1;
    end
  end

  assign lagc_nxt = (lagc_r == LAG_W'(MAX_LAGS - 1)) ? '0 : lagc_r + LAG_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      p_r    <= (in_data.corr_value > 0) ? in_data.corr_value : 32'd1;
      lg_r   <= '0;
    end else if (cmd.log_step && p_sh != 32'd0) begin
      p_r  <= p_sh;
      lg_r <= lg_r + log_sh;
    end
    if (cmd.mul_sel != MUL_NONE) begin
      prod_r <= opa * opb;
    end
    if (cmd.num_cap) begin
      num_r <= prod_r[30:15];
    end
    if (cmd.hold_cap) begin
      hold_r <= prod_r;
    end
    if (cmd.sq_cap) begin
      sqe_r <= sq;
    end
    if (cmd.out_load) begin
      out_r.best_lag   <= 9'(lag0_r);
      out_r.second_lag <= 9'(lag1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r   <= '0;
      energy_r <= 32'd1;
      num0_r   <= -16'sd1;
      num1_r   <= -16'sd1;
      den0_r   <= '0;
      den1_r   <= '0;
      lag0_r   <= '0;
      lag1_r   <= LAG_W'(1);
      lagc_r   <= '0;
    end else if (cmd.start_commit) begin
      norm_r   <= $signed({1'b0, lg_r}) - 6'sd14;
      energy_r <= 32'd1;
      num0_r   <= -16'sd1;
      num1_r   <= -16'sd1;
      den0_r   <= '0;
      den1_r   <= '0;
      lag0_r   <= '0;
      lag1_r   <= LAG_W'(1);
      lagc_r   <= '0;
    end else begin
      if (cmd.eacc) begin
        energy_r <= energy_r + sq;
      end
      if (cmd.top_upd) begin
        if (gt) begin
          num1_r <= num0_r;
          den1_r <= den0_r;
          lag1_r <= lag0_r;
          num0_r <= num_r;
          den0_r <= energy_r;
          lag0_r <= lagc_r;
        end else begin
          num1_r <= num_r;
          den1_r <= energy_r;
          lag1_r <= lagc_r;
        end
      end
      if (cmd.slide) begin
        energy_r <= energy_nxt;
        lagc_r   <= lagc_nxt;
      end
    end
  end

  assign stat.gt       = gt;
  assign stat.last_lag = item_r.last_lag;
  assign out_data      = out_r;

  a_energy_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.slide |=> (energy_r != 32'd0 && !energy_r[31]))
    else $error("window energy not positive after slide");

endmodule

// File: src/tpls_ctrl.sv
// controller: sequences each item through the shared datapath
module tpls_ctrl
  import tpls_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  stat_t    stat,
  output cmd_t     cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_LOG    = 4'd1;
  localparam logic [3:0] ST_LOGEND = 4'd2;
  localparam logic [3:0] ST_ESQ    = 4'd3;
  localparam logic [3:0] ST_EACC   = 4'd4;
  localparam logic [3:0] ST_XX     = 4'd5;
  localparam logic [3:0] ST_N1A    = 4'd6;
  localparam logic [3:0] ST_N1B    = 4'd7;
  localparam logic [3:0] ST_C1     = 4'd8;
  localparam logic [3:0] ST_N0A    = 4'd9;
  localparam logic [3:0] ST_N0B    = 4'd10;
  localparam logic [3:0] ST_C0     = 4'd11;
  localparam logic [3:0] ST_SQE    = 4'd12;
  localparam logic [3:0] ST_SQL    = 4'd13;
  localparam logic [3:0] ST_SLIDE  = 4'd14;
  localparam logic [3:0] ST_OUT    = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic [2:0] log_idx_r, log_idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    log_idx_nxt = log_idx_r;
    cmd         = '0;
    cmd.mul_sel = MUL_NONE;
    cmd.log_idx = log_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load    = accept;
        log_idx_nxt = '0;
        if (accept) begin
          unique case (in_data.op)
            OP_START:  state_nxt = ST_LOG;
            OP_ENERGY: state_nxt = ST_ESQ;
            OP_LAG:    state_nxt = (in_data.corr_value > 0) ? ST_XX : ST_SQE;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOG: begin
        cmd.log_step = 1'b1;
        log_idx_nxt  = log_idx_r + 3'd1;
        if (log_idx_r == 3'(LOG_STEPS - 1)) begin
          state_nxt = ST_LOGEND;
        end
      end
      ST_LOGEND: begin
        cmd.start_commit = 1'b1;
        state_nxt        = ST_IDLE;
      end
      ST_ESQ: begin
        cmd.mul_sel = MUL_ENT;
        state_nxt   = ST_EACC;
      end
      ST_EACC: begin
        cmd.eacc  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_XX: begin
        cmd.mul_sel = MUL_XX;
        state_nxt   = ST_N1A;
      end
      ST_N1A: begin
        cmd.num_cap = 1'b1;
        cmd.mul_sel = MUL_ND1;
        state_nxt   = ST_N1B;
      end
      ST_N1B: begin
        cmd.hold_cap = 1'b1;
        cmd.mul_sel  = MUL_N1E;
        state_nxt    = ST_C1;
      end
      ST_C1: begin
        state_nxt = stat.gt ? ST_N0A : ST_SQE;
      end
      ST_N0A: begin
        cmd.mul_sel = MUL_ND0;
        state_nxt   = ST_N0B;
      end
      ST_N0B: begin
        cmd.hold_cap = 1'b1;
        cmd.mul_sel  = MUL_N0E;
        state_nxt    = ST_C0;
      end
      ST_C0: begin
        cmd.top_upd = 1'b1;
        state_nxt   = ST_SQE;
      end
      ST_SQE: begin
        cmd.mul_sel = MUL_ENT;
        state_nxt   = ST_SQL;
      end
      ST_SQL: begin
        cmd.sq_cap  = 1'b1;
        cmd.mul_sel = MUL_LEV;
        state_nxt   = ST_SLIDE;
      end
      ST_SLIDE: begin
        cmd.slide = 1'b1;
        state_nxt = stat.last_lag ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      log_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      log_idx_r   <= log_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_c0_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_C0 |-> $past(state_r) == ST_N0B)
    else $error("second compare without its products");

  a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.op == OP_NONE) |=> state_r == ST_IDLE)
    else $error("unused op started work");

endmodule
